@@ sv/rbs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbs_pkg: shared definitions for the ray/box slab intersection block
// Default number format, axis count and configuration register indexes.
// ----------------------------------------------------------------------------
package rbs_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int NUM_AXES        = 3;
  localparam int CFG_INDEX_WIDTH = 3;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_ORIGIN_Z = 3'd2,
    REG_RECIP_X  = 3'd3,
    REG_RECIP_Y  = 3'd4,
    REG_RECIP_Z  = 3'd5,
    REG_MAX_DIST = 3'd6
  } cfg_reg_t;

endpackage

@@ sv/rbs_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbs_cfg_regs: ray configuration registers
// Holds origin, reciprocal direction and maximum distance of the ray.
// ----------------------------------------------------------------------------
module rbs_cfg_regs #(
  parameter int COORD_WIDTH = rbs_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = rbs_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [rbs_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  logic [COORD_WIDTH-1:0]                 cfg_data,
  output logic signed [COORD_WIDTH-1:0]          origin [rbs_pkg::NUM_AXES],
  output logic signed [COORD_WIDTH-1:0]          recip  [rbs_pkg::NUM_AXES],
  output logic signed [COORD_WIDTH-1:0]          max_distance
);

  localparam logic signed [COORD_WIDTH-1:0] ONE =
    COORD_WIDTH'(1) << FRAC_BITS;
  localparam logic signed [COORD_WIDTH-1:0] MAX_POS =
    {1'b0, {(COORD_WIDTH-1){1'b1}}};

  // Writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < rbs_pkg::NUM_AXES; a++) begin
        origin[a] <= '0;
        recip[a]  <= ONE;
      end
      max_distance <= MAX_POS;
    end else if (cfg_valid) begin
      case (rbs_pkg::cfg_reg_t'(cfg_index))
        rbs_pkg::REG_ORIGIN_X: origin[0]    <= cfg_data;
        rbs_pkg::REG_ORIGIN_Y: origin[1]    <= cfg_data;
        rbs_pkg::REG_ORIGIN_Z: origin[2]    <= cfg_data;
        rbs_pkg::REG_RECIP_X:  recip[0]     <= cfg_data;
        rbs_pkg::REG_RECIP_Y:  recip[1]     <= cfg_data;
        rbs_pkg::REG_RECIP_Z:  recip[2]     <= cfg_data;
        rbs_pkg::REG_MAX_DIST: max_distance <= cfg_data;
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

endmodule

@@ sv/rbs_slab_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbs_slab_mul: one slab parameter
// Forms (bound - origin) * recip exactly, scales with floor, saturates.
// ----------------------------------------------------------------------------
module rbs_slab_mul #(
  parameter int COORD_WIDTH = rbs_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = rbs_pkg::FRAC_BITS_DEF
) (
  input  logic signed [COORD_WIDTH-1:0] bound,
  input  logic signed [COORD_WIDTH-1:0] origin,
  input  logic signed [COORD_WIDTH-1:0] recip,
  output logic signed [COORD_WIDTH-1:0] t
);

  localparam int PW = 2 * COORD_WIDTH + 1;

  localparam logic signed [PW-1:0] LIM_HI =
    {{(COORD_WIDTH+2){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [PW-1:0] LIM_LO =
    {{(COORD_WIDTH+2){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

  logic signed [COORD_WIDTH:0] diff;
  logic signed [PW-1:0]        prod;
  logic signed [PW-1:0]        scaled;

  // Exact difference, one bit wider; never wraps.
  assign diff   = {bound[COORD_WIDTH-1], bound} - {origin[COORD_WIDTH-1], origin};
  assign prod   = PW'(diff) * PW'(recip);
  // Arithmetic shift rounds toward minus infinity.
  assign scaled = prod >>> FRAC_BITS;

  always_comb begin
    if (scaled > LIM_HI) begin
      t = LIM_HI[COORD_WIDTH-1:0];
    end else if (scaled < LIM_LO) begin
      t = LIM_LO[COORD_WIDTH-1:0];
    end else begin
      t = scaled[COORD_WIDTH-1:0];
    end
  end

endmodule

@@ sv/rbs_resolve.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbs_resolve: slab reduction and hit flags
// Orders each axis pair, keeps the largest entry and smallest exit.
// ----------------------------------------------------------------------------
module rbs_resolve #(
  parameter int COORD_WIDTH = rbs_pkg::COORD_WIDTH_DEF
) (
  input  logic signed [COORD_WIDTH-1:0] t_lo [rbs_pkg::NUM_AXES],
  input  logic signed [COORD_WIDTH-1:0] t_hi [rbs_pkg::NUM_AXES],
  input  logic signed [COORD_WIDTH-1:0] max_distance,
  output logic signed [COORD_WIDTH-1:0] t_near,
  output logic signed [COORD_WIDTH-1:0] t_far,
  output logic                          hit,
  output logic                          hit_in_range
);

  logic signed [COORD_WIDTH-1:0] enter [rbs_pkg::NUM_AXES];
  logic signed [COORD_WIDTH-1:0] leave [rbs_pkg::NUM_AXES];

  always_comb begin
    for (int a = 0; a < rbs_pkg::NUM_AXES; a++) begin
      if (t_lo[a] < t_hi[a]) begin
        enter[a] = t_lo[a];
        leave[a] = t_hi[a];
      end else begin
        enter[a] = t_hi[a];
        leave[a] = t_lo[a];
      end
    end
  end

  always_comb begin
    t_near = enter[0];
    t_far  = leave[0];
    for (int a = 1; a < rbs_pkg::NUM_AXES; a++) begin
      if (enter[a] > t_near) t_near = enter[a];
      if (leave[a] < t_far)  t_far  = leave[a];
    end
  end

  assign hit          = (t_far >= t_near) && (t_far >= 0);
  assign hit_in_range = hit && (t_near <= max_distance);

endmodule

@@ sv/ray_box_slab_intersection.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_box_slab_intersection: ray versus axis-aligned box, slab method
// Tests one box a cycle against a ray held in configuration registers.
// ----------------------------------------------------------------------------
// Using the block: pulse start with a box on the box_* ports and the box is
// taken at that edge; busy is always low, so a new box may be issued every
// cycle. After the input, slab and result registers, done goes high for
// exactly one cycle with t_near, t_far, hit and hit_in_range for that
// box. Results come
// out in issue order and are not held: the receiver must take each beat in
// the cycle it appears, since the block has no way to be stalled. Sustained
// rate is one box per clock, set by the six slab multipliers working in
// parallel in the product stage. Values are signed fixed point with
// FRAC_BITS fraction bits. Write the ray (origin, reciprocal direction,
// max distance) through the cfg_* port only while no box is in flight.
// ----------------------------------------------------------------------------
module ray_box_slab_intersection #(
  parameter int COORD_WIDTH = rbs_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = rbs_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // command channel
  input  logic                                start,
  output logic                                busy,
  input  logic signed [COORD_WIDTH-1:0]       box_low_x,
  input  logic signed [COORD_WIDTH-1:0]       box_low_y,
  input  logic signed [COORD_WIDTH-1:0]       box_low_z,
  input  logic signed [COORD_WIDTH-1:0]       box_high_x,
  input  logic signed [COORD_WIDTH-1:0]       box_high_y,
  input  logic signed [COORD_WIDTH-1:0]       box_high_z,
  // result channel
  output logic                                done,
  output logic signed [COORD_WIDTH-1:0]       t_near,
  output logic signed [COORD_WIDTH-1:0]       t_far,
  output logic                                hit,
  output logic                                hit_in_range,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rbs_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [COORD_WIDTH-1:0]              cfg_data
);

  localparam int NA = rbs_pkg::NUM_AXES;

  // Ray registers.
  logic signed [COORD_WIDTH-1:0] origin [NA];
  logic signed [COORD_WIDTH-1:0] recip  [NA];
  logic signed [COORD_WIDTH-1:0] max_distance;

  // Stage 0: input register.
  logic                          box_valid;
  logic signed [COORD_WIDTH-1:0] low_r  [NA];
  logic signed [COORD_WIDTH-1:0] high_r [NA];

  // Stage 1: slab parameters.
  logic signed [COORD_WIDTH-1:0] t_lo_c [NA];
  logic signed [COORD_WIDTH-1:0] t_hi_c [NA];
  logic                          slab_valid;
  logic signed [COORD_WIDTH-1:0] t_lo_r [NA];
  logic signed [COORD_WIDTH-1:0] t_hi_r [NA];

  // Stage 2 combinational outputs.
  logic signed [COORD_WIDTH-1:0] near_c;
  logic signed [COORD_WIDTH-1:0] far_c;
  logic                          hit_c;
  logic                          in_range_c;

  // Every stage advances each cycle; nothing can hold a beat.
  assign busy = 1'b0;

  rbs_cfg_regs #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .origin       (origin),
    .recip        (recip),
    .max_distance (max_distance)
  );

  // Capture the box on accept.
  always_ff @(posedge clk) begin
    if (rst) begin
      box_valid <= 1'b0;
    end else begin
      box_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      low_r[0]  <= box_low_x;
      low_r[1]  <= box_low_y;
      low_r[2]  <= box_low_z;
      high_r[0] <= box_high_x;
      high_r[1] <= box_high_y;
      high_r[2] <= box_high_z;
    end
  end

  // Six slab products, one per bound per axis, all in parallel.
  for (genvar a = 0; a < NA; a++) begin : g_axis
    rbs_slab_mul #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
    ) u_mul_lo (
      .bound  (low_r[a]),
      .origin (origin[a]),
      .recip  (recip[a]),
      .t      (t_lo_c[a])
    );

    rbs_slab_mul #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
    ) u_mul_hi (
      .bound  (high_r[a]),
      .origin (origin[a]),
      .recip  (recip[a]),
      .t      (t_hi_c[a])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slab_valid <= 1'b0;
    end else begin
      slab_valid <= box_valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < NA; a++) begin
      t_lo_r[a] <= t_lo_c[a];
      t_hi_r[a] <= t_hi_c[a];
    end
  end

  // Order, reduce and flag.
  rbs_resolve #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_resolve (
    .t_lo         (t_lo_r),
    .t_hi         (t_hi_r),
    .max_distance (max_distance),
    .t_near       (near_c),
    .t_far        (far_c),
    .hit          (hit_c),
    .hit_in_range (in_range_c)
  );

  // Result register: one beat per cycle, strobed by done.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= slab_valid;
    end
  end

  always_ff @(posedge clk) begin
    t_near       <= near_c;
    t_far        <= far_c;
    hit          <= hit_c;
    hit_in_range <= in_range_c;
  end

endmodule
